@@ src/kspt_pkg.sv @@
// shared types, codes and defaults for the keyed sorted priority table
package kspt_pkg;

    localparam int KEY_W   = 32;
    localparam int SCORE_W = 16;
    localparam int ARR_W   = 64;
    localparam int CNT_W   = 6;
    localparam int DefCapacity = 32;
    localparam int ENTRY_W = KEY_W + SCORE_W + ARR_W;

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FETCH  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [ARR_W-1:0]   arrival;
    } t_entry;

    typedef struct packed {
        logic [1:0]         status;
        logic               entry_valid;
        logic [KEY_W-1:0]   out_key;
        logic [SCORE_W-1:0] out_score;
        logic [ARR_W-1:0]   out_arrival;
        logic [CNT_W-1:0]   entry_count;
        logic               last;
    } t_result;

endpackage

@@ src/keyed_sorted_priority_table_unit.sv @@
// top level of the keyed sorted priority table
//
// slave side: s_axis_* carries one request {opcode, key, score, arrival}
// master side: m_axis_* carries results; tlast marks the last result of a
// request, tuser carries status and entry_valid
// upsert: key-search pass over the count (one entry a cycle, reads through
// the registered memory port), then a close-up shift when the key is
// present, then an insert-position scan and an open-up shift, each a
// read-modify-write on the single memory
// remove: search pass, then close-up shift pass
// fetch: one result per entry streamed from the memory, each a read, then a
// load of the result register, while the receiver takes them
// the block works on one request at a time; s_axis_tready is high only while
// the engine is idle and the result register is empty
// reset clears the count and the control state; the memory contents are not
// cleared, since only slots below the count are ever read
// a stalled receiver holds the result register and the engine waits
module keyed_sorted_priority_table_unit #(
    parameter int CAPACITY = kspt_pkg::DefCapacity
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0], player_key[33:2], score[49:34], arrival[113:50], zero fill
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_key[31:0], out_score[47:32], out_arrival[111:48], entry_count[117:112]
    output logic [119:0] m_axis_tdata,
    // status[1:0], entry_valid[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import kspt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_SRCH   = 8'b00000010,
        S_DECIDE = 8'b00000100,
        S_DEL    = 8'b00001000,
        S_INS    = 8'b00010000,
        S_PUT    = 8'b00100000,
        S_FETCH  = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state             r_state, n_state;
    t_opcode            r_op;
    t_entry             r_item;
    logic [PW-1:0]      r_cnt, n_cnt;
    logic [PW-1:0]      r_idx, n_idx;        // address issued
    logic               r_rdv, n_rdv;        // data for r_ridx arrives
    logic [PW-1:0]      r_ridx, n_ridx;
    logic               r_found, n_found;
    logic [PW-1:0]      r_fpos, n_fpos;      // found position, then insert position
    logic               r_pfound, n_pfound;  // insert position found
    logic               r_ovld, n_ovld;
    t_result            r_res, n_res;
    logic [1:0]         r_st, n_st;

    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    t_entry             w_wdata, w_rdata;

    kspt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {2'b00, r_res.entry_count, r_res.out_arrival,
                            r_res.out_score, r_res.out_key};
    assign m_axis_tuser  = {r_res.entry_valid, r_res.status};
    assign m_axis_tlast  = r_res.last;

    logic w_take, w_out_free, w_le;
    assign w_take     = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovld || m_axis_tready;
    // stored entry orders at or before the new item
    assign w_le = (w_rdata.score < r_item.score) ||
                  ((w_rdata.score == r_item.score) &&
                   (w_rdata.arrival <= r_item.arrival));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_rdv    = 1'b0;
        n_ridx   = r_ridx;
        n_found  = r_found;
        n_fpos   = r_fpos;
        n_pfound = r_pfound;
        n_ovld   = r_ovld && !m_axis_tready;
        n_res    = r_res;
        n_st     = r_st;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = r_item;
        w_raddr  = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_pfound = 1'b0;
                    n_st     = ST_OK;
                    case (t_opcode'(s_axis_tdata[1:0]))
                        OP_UPSERT, OP_REMOVE: n_state = S_SRCH;
                        OP_FETCH: begin
                            if (r_cnt == '0) begin
                                n_st    = ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SRCH: begin
                // issue reads over the table, check the returning data
                if (r_idx < r_cnt) begin
                    n_rdv  = 1'b1;
                    n_ridx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_rdv && !r_found && (w_rdata.key == r_item.key)) begin
                    n_found = 1'b1;
                    n_fpos  = r_ridx;
                end
                if (!(r_idx < r_cnt) && !r_rdv) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_op == OP_REMOVE && !r_found) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else if (r_op == OP_UPSERT && !r_found &&
                             r_cnt >= PW'(CAPACITY)) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else if (r_found) begin
                    n_idx   = r_fpos + 1'b1;
                    n_state = S_DEL;
                end else begin
                    n_idx   = '0;
                    n_state = S_INS;
                end
            end
            S_DEL: begin
                // read idx, write data back one slot lower
                if (r_rdv) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_ridx - 1'b1);
                    w_wdata = w_rdata;
                end
                if (r_idx < r_cnt) begin
                    n_rdv  = 1'b1;
                    n_ridx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end else if (!r_rdv) begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_op == OP_UPSERT) begin
                        n_idx   = '0;
                        n_state = S_INS;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INS: begin
                // find insert position scanning up, then shift from the top down
                if (!r_pfound) begin
                    if (r_rdv && !w_le) begin
                        n_pfound = 1'b1;
                        n_fpos   = r_ridx;
                        n_idx    = r_cnt;
                    end else if (r_idx < r_cnt) begin
                        n_rdv  = 1'b1;
                        n_ridx = r_idx;
                        n_idx  = r_idx + 1'b1;
                    end else if (!r_rdv) begin
                        n_pfound = 1'b1;
                        n_fpos   = r_cnt;
                        n_idx    = r_cnt;
                    end
                end else begin
                    if (r_rdv) begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_ridx + 1'b1);
                        w_wdata = w_rdata;
                    end
                    if (r_idx > r_fpos) begin
                        n_rdv   = 1'b1;
                        n_ridx  = r_idx - 1'b1;
                        n_idx   = r_idx - 1'b1;
                        w_raddr = AW'(r_idx - 1'b1);
                    end else if (!r_rdv) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_fpos[AW-1:0];
                w_wdata = r_item;
                n_cnt   = r_cnt + 1'b1;
                n_state = S_DONE;
            end
            S_FETCH: begin
                // one read outstanding; the result register must be free
                if (r_rdv) begin
                    n_ovld            = 1'b1;
                    n_res.status      = ST_OK;
                    n_res.entry_valid = 1'b1;
                    n_res.out_key     = w_rdata.key;
                    n_res.out_score   = w_rdata.score;
                    n_res.out_arrival = w_rdata.arrival;
                    n_res.entry_count = CNT_W'(r_cnt);
                    n_res.last        = (r_ridx + 1'b1 == r_cnt);
                    if (r_ridx + 1'b1 == r_cnt) begin
                        n_state = S_IDLE;
                    end
                end else if (w_out_free) begin
                    n_rdv  = 1'b1;
                    n_ridx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovld = 1'b1;
                    n_res  = '{status: r_st, entry_valid: 1'b0, out_key: '0,
                               out_score: '0, out_arrival: '0,
                               entry_count: CNT_W'(r_cnt), last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rdv   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rdv   <= n_rdv;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op           <= t_opcode'(s_axis_tdata[1:0]);
            r_item.key     <= s_axis_tdata[33:2];
            r_item.score   <= s_axis_tdata[49:34];
            r_item.arrival <= s_axis_tdata[113:50];
        end
        r_idx    <= n_idx;
        r_ridx   <= n_ridx;
        r_found  <= n_found;
        r_fpos   <= n_fpos;
        r_pfound <= n_pfound;
        r_res    <= n_res;
        r_st     <= n_st;
    end

endmodule

@@ src/kspt_mem.sv @@
// entry store with one write port and a registered read port
module kspt_mem #(
    parameter int DEPTH = kspt_pkg::DefCapacity,
    parameter int AW    = 5
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  kspt_pkg::t_entry        i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output kspt_pkg::t_entry        o_rdata
);
    import kspt_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
